// File: sv/srg_pkg.sv
// ----------------------------------------------------------------------------
// srg_pkg: shared types and constants of the subtractive random generator
// Request and response payloads, table geometry, and the operation codes of
// the shared subtract unit.
// ----------------------------------------------------------------------------
package srg_pkg;

  localparam int unsigned TableDepth = 55;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned IdxW       = 6;

  localparam logic [31:0] Mbig  = 32'd2147483647;
  localparam logic [31:0] Mseed = 32'd161803398;
  localparam logic [31:0] MinInt = 32'h8000_0000;

  // Scatter order: slot of step i is (21 * i) mod 55 minus one, first slot 20.
  localparam logic [AddrW-1:0] ScatStep  = AddrW'(21);
  localparam logic [AddrW-1:0] ScatFirst = AddrW'(20);
  localparam logic [AddrW-1:0] LastSlot  = AddrW'(TableDepth - 1);
  // Mixing pairs slot j with slot (j + 31) mod 55.
  localparam logic [AddrW-1:0] MixFirst  = AddrW'(31);
  localparam logic [IdxW-1:0]  IdxB0     = IdxW'(21);
  localparam logic [IdxW-1:0]  IdxLimit  = IdxW'(56);

  typedef enum logic [1:0] {
    ALU_RAW,
    ALU_FOLD,
    ALU_DRAW
  } alu_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ABS,
    S_MJ,
    S_SCAT,
    S_MIX_RD,
    S_MIX_WR,
    S_DRAW_RD,
    S_DRAW_WR
  } state_e;

  typedef struct packed {
    logic reseed;
    logic last_request;
  } srg_req_t;

  typedef struct packed {
    logic [30:0] value;
    logic [7:0]  byte_out;
    logic        last;
  } srg_rsp_t;

  typedef struct packed {
    logic             rd_en;
    logic [AddrW-1:0] raddr_a;
    logic [AddrW-1:0] raddr_b;
    logic             we;
    logic [AddrW-1:0] waddr;
  } tbl_ctrl_t;

endpackage

// File: sv/srg_table.sv
// ----------------------------------------------------------------------------
// srg_table: generator state table
// 55 words, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module srg_table
  import srg_pkg::*;
(
  input  logic        clk_i,
  input  tbl_ctrl_t   ctrl_i,
  input  logic [31:0] wdata_i,
  output logic [31:0] rdata_a_o,
  output logic [31:0] rdata_b_o
);

  logic [31:0] mem [TableDepth];
  logic [31:0] rdata_a_q;
  logic [31:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem[ctrl_i.waddr] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rdata_a_q <= mem[ctrl_i.raddr_a];
      rdata_b_q <= mem[ctrl_i.raddr_b];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: sv/srg_alu.sv
// ----------------------------------------------------------------------------
// srg_alu: shared subtract unit
// Computes a - b in 32 bits, optionally folded into range by adding 2^31 - 1
// when negative, with the draw rule that replaces 2^31 - 1 by 2^31 - 2.
// ----------------------------------------------------------------------------
module srg_alu
  import srg_pkg::*;
(
  input  alu_op_e     op_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] y_o
);

  logic [31:0] diff;
  logic [31:0] diff_m1;
  logic [31:0] folded;

  // Adding 2^31 - 1 equals subtracting one and flipping the sign bit, so the
  // folded value comes from a second adder in parallel with the first.
  assign diff    = a_i - b_i;
  assign diff_m1 = a_i + ~b_i;
  assign folded  = diff[31] ? {~diff_m1[31], diff_m1[30:0]} : diff;

  always_comb begin
    case (op_i)
      ALU_FOLD: y_o = folded;
      ALU_DRAW: y_o = (diff == Mbig) ? (Mbig - 32'd1) : folded;
      default:  y_o = diff;
    endcase
  end

endmodule

// File: sv/subtractive_random_generator.sv
// ----------------------------------------------------------------------------
// subtractive_random_generator: subtractive random number generator
// Top level with request and response channels, seed register and sequencer.
// ----------------------------------------------------------------------------
// Each request yields one 31-bit draw with its low byte. A plain draw first
// reads two table entries into registers, then subtracts them in the shared
// unit and writes the result back; the write back waits while the output
// register still holds an unread response. The first request after reset,
// and any request with reseed set, first rebuilds the table from the seed
// register: the seed magnitude, 54 scatter writes, and four mixing passes
// of 55 entries, each entry one read and then one subtract and write. The
// block takes no request while a draw or a rebuild is under way; a finished
// response waits in an output register. Write the seed only while the block
// is idle.
module subtractive_random_generator
  import srg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  srg_req_t    in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output srg_rsp_t    out_rsp_o
);

  state_e state_q, state_d;

  logic [31:0]      seed_q;
  logic             seeded_q;
  logic [IdxW-1:0]  idx_a_q, idx_b_q;
  logic [IdxW-1:0]  idx_a_nxt, idx_b_nxt;
  logic [31:0]      mj_q, mk_q;
  logic [AddrW-1:0] slot_q;
  logic [AddrW-1:0] pair_q;
  logic [AddrW-1:0] slot_step;
  logic [1:0]       pass_q;
  logic             last_q;
  logic             out_valid_q;
  srg_rsp_t         out_q;

  alu_op_e     alu_op;
  logic [31:0] alu_a, alu_b, alu_y;
  tbl_ctrl_t   tbl_ctrl;
  logic [31:0] tbl_wdata;
  logic [31:0] rdata_a, rdata_b;
  logic        in_fire;
  logic        out_free;
  logic        mix_row_end;

  // Scatter count: runs from 0 to 53 over the 54 steps, the last one ends the scatter phase.
  logic [AddrW-1:0] scat_cnt_q;
  logic             mk_scat_last;

  function automatic logic [IdxW-1:0] next_idx(logic [IdxW-1:0] idx);
    logic [IdxW-1:0] t;
    t = idx + IdxW'(1);
    if (t >= IdxLimit || t == '0) begin
      t = IdxW'(1);
    end
    return t;
  endfunction

  assign in_ready_o   = (state_q == S_IDLE);
  assign in_fire      = in_valid_i & in_ready_o;
  assign out_free     = !out_valid_q || out_ready_i;
  assign idx_a_nxt    = next_idx(idx_a_q);
  assign idx_b_nxt    = next_idx(idx_b_q);
  assign mix_row_end  = (slot_q == LastSlot);
  assign mk_scat_last = (scat_cnt_q == LastSlot - AddrW'(1));

  // The scatter stores the running value before it is updated.
  assign tbl_wdata = (state_q == S_SCAT) ? mk_q : alu_y;

  // Next scatter slot: (slot + 21) mod 55.
  always_comb begin
    logic [AddrW:0] sum;
    sum = {1'b0, slot_q} + {1'b0, ScatStep};
    if (sum >= (AddrW+1)'(TableDepth)) begin
      slot_step = AddrW'(sum - (AddrW+1)'(TableDepth));
    end else begin
      slot_step = sum[AddrW-1:0];
    end
  end

  srg_alu u_alu (
    .op_i (alu_op),
    .a_i  (alu_a),
    .b_i  (alu_b),
    .y_o  (alu_y)
  );

  srg_table u_table (
    .clk_i     (clk_i),
    .ctrl_i    (tbl_ctrl),
    .wdata_i   (tbl_wdata),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    alu_op   = ALU_RAW;
    alu_a    = '0;
    alu_b    = '0;
    tbl_ctrl = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (in_req_i.reseed || !seeded_q) ? S_ABS : S_DRAW_RD;
        end
      end
      S_ABS: begin
        // Seed magnitude; the most negative seed maps to 2^31 - 1.
        if (seed_q == MinInt) begin
          alu_a = Mbig;
        end else if (seed_q[31]) begin
          alu_b = seed_q;
        end else begin
          alu_a = seed_q;
        end
        state_d = S_MJ;
      end
      S_MJ: begin
        alu_a          = Mseed;
        alu_b          = mj_q;
        tbl_ctrl.we    = 1'b1;
        tbl_ctrl.waddr = LastSlot;
        state_d        = S_SCAT;
      end
      S_SCAT: begin
        alu_op         = ALU_FOLD;
        alu_a          = mj_q;
        alu_b          = mk_q;
        tbl_ctrl.we    = 1'b1;
        tbl_ctrl.waddr = slot_q;
        if (mk_scat_last) begin
          state_d = S_MIX_RD;
        end
      end
      S_MIX_RD: begin
        tbl_ctrl.rd_en   = 1'b1;
        tbl_ctrl.raddr_a = slot_q;
        tbl_ctrl.raddr_b = pair_q;
        state_d          = S_MIX_WR;
      end
      S_MIX_WR: begin
        alu_op         = ALU_FOLD;
        alu_a          = rdata_a;
        alu_b          = rdata_b;
        tbl_ctrl.we    = 1'b1;
        tbl_ctrl.waddr = slot_q;
        state_d        = (mix_row_end && pass_q == 2'd3) ? S_DRAW_RD : S_MIX_RD;
      end
      S_DRAW_RD: begin
        tbl_ctrl.rd_en   = 1'b1;
        tbl_ctrl.raddr_a = AddrW'(idx_a_nxt - IdxW'(1));
        tbl_ctrl.raddr_b = AddrW'(idx_b_nxt - IdxW'(1));
        state_d          = S_DRAW_WR;
      end
      S_DRAW_WR: begin
        alu_op         = ALU_DRAW;
        alu_a          = rdata_a;
        alu_b          = rdata_b;
        tbl_ctrl.waddr = AddrW'(idx_a_q - IdxW'(1));
        if (out_free) begin
          tbl_ctrl.we = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= '0;
      seeded_q    <= 1'b0;
      idx_a_q     <= '0;
      idx_b_q     <= IdxB0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      if (state_q == S_DRAW_WR && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_MIX_WR && mix_row_end && pass_q == 2'd3) begin
        seeded_q <= 1'b1;
        idx_a_q  <= '0;
        idx_b_q  <= IdxB0;
      end
      if (state_q == S_DRAW_RD) begin
        idx_a_q <= idx_a_nxt;
        idx_b_q <= idx_b_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          last_q <= in_req_i.last_request;
        end
      end
      S_ABS: begin
        mj_q <= alu_y;
      end
      S_MJ: begin
        mj_q       <= alu_y;
        mk_q       <= 32'd1;
        slot_q     <= ScatFirst;
        scat_cnt_q <= '0;
      end
      S_SCAT: begin
        mk_q       <= alu_y;
        mj_q       <= mk_q;
        scat_cnt_q <= scat_cnt_q + AddrW'(1);
        if (mk_scat_last) begin
          slot_q <= '0;
          pair_q <= MixFirst;
          pass_q <= '0;
        end else begin
          slot_q <= slot_step;
        end
      end
      S_MIX_WR: begin
        slot_q <= mix_row_end ? '0 : slot_q + AddrW'(1);
        pair_q <= (pair_q == LastSlot) ? '0 : pair_q + AddrW'(1);
        if (mix_row_end) begin
          pass_q <= pass_q + 2'd1;
        end
      end
      S_DRAW_WR: begin
        if (out_free) begin
          out_q.value    <= alu_y[30:0];
          out_q.byte_out <= alu_y[7:0];
          out_q.last     <= last_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != S_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_draw_needs_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DRAW_RD |-> seeded_q || (state_q == S_DRAW_RD && $past(state_q) == S_MIX_WR))
    else $error("draw started on an unseeded table");

  a_response_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAW_WR && out_free) |=> out_valid_q && state_q == S_IDLE)
    else $error("finished draw did not reach the output register");

  a_index_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_a_q < IdxLimit && idx_b_q < IdxLimit && idx_b_q != '0)
    else $error("read index out of table range");

endmodule
